>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scan-out unit.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define VSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define VSU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/vsu_pkg.sv
// Types, constants and register codes of the line-doubled VGA scan-out unit.
// No dependencies.
`timescale 1ns / 1ps

package vsu_pkg;

   // buffer geometry defaults
   localparam int DEF_BUF_WIDTH  = 320;
   localparam int DEF_BUF_HEIGHT = 240;

   // field widths
   localparam int KIND_W   = 1;
   localparam int COLUMN_W = 9;
   localparam int ROW_W    = 8;
   localparam int VALUE_W  = 8;
   localparam int PIXEL_W  = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam int LINE_TICKS_W = 13;
   localparam int PIX_TICKS_W  = 4;
   localparam int VSYNC_W      = 4;
   localparam int LINES_W      = 10;
   localparam int VIS_LINES_W  = 9;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 13;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINE_TICKS    = 3'd0,
      REG_HSYNC_TICKS   = 3'd1,
      REG_ACTIVE_START  = 3'd2,
      REG_PIXEL_TICKS   = 3'd3,
      REG_VSYNC_LINES   = 3'd4,
      REG_FRAME_LINES   = 3'd5,
      REG_FIRST_VISIBLE = 3'd6,
      REG_VISIBLE_LINES = 3'd7
   } vsu_reg_type;

   typedef struct packed {
      logic [LINE_TICKS_W-1:0] line_ticks;
      logic [LINE_TICKS_W-1:0] hsync_ticks;
      logic [LINE_TICKS_W-1:0] active_start;
      logic [PIX_TICKS_W-1:0]  pixel_ticks;
      logic [VSYNC_W-1:0]      vsync_lines;
      logic [LINES_W-1:0]      frame_lines;
      logic [LINES_W-1:0]      first_visible_line;
      logic [VIS_LINES_W-1:0]  visible_lines;
   } vsu_cfg_type;

   localparam vsu_cfg_type CFG_RESET = '{
      line_ticks:         13'd3814,
      hsync_ticks:        13'd465,
      active_start:       13'd685,
      pixel_ticks:        4'd4,
      vsync_lines:        4'd2,
      frame_lines:        10'd526,
      first_visible_line: 10'd12,
      visible_lines:      9'd480
   };

   // sync levels and active flag of one tick
   typedef struct packed {
      logic hsync_n;
      logic vsync_n;
      logic active;
   } vsu_sync_type;

   // buffer access carried by the address stage
   typedef struct packed {
      logic write;
      logic read;
   } vsu_op_type;

endpackage

>>> rtl/vsu_csr.sv
// Timing register file of the scan-out unit, written through the csr channel.
// Depends on vsu_pkg.
`timescale 1ns / 1ps

module vsu_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_valid,
   input  logic [vsu_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [vsu_pkg::CSR_DATA_W-1:0]    wr_data,
   output vsu_pkg::vsu_cfg_type              cfg
);

   vsu_pkg::vsu_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= vsu_pkg::CFG_RESET;
      end else if (wr_valid) begin
         unique case (vsu_pkg::vsu_reg_type'(wr_index))
            vsu_pkg::REG_LINE_TICKS:
               cfg_ff.line_ticks <= wr_data[vsu_pkg::LINE_TICKS_W-1:0];
            vsu_pkg::REG_HSYNC_TICKS:
               cfg_ff.hsync_ticks <= wr_data[vsu_pkg::LINE_TICKS_W-1:0];
            vsu_pkg::REG_ACTIVE_START:
               cfg_ff.active_start <= wr_data[vsu_pkg::LINE_TICKS_W-1:0];
            vsu_pkg::REG_PIXEL_TICKS:
               cfg_ff.pixel_ticks <= wr_data[vsu_pkg::PIX_TICKS_W-1:0];
            vsu_pkg::REG_VSYNC_LINES:
               cfg_ff.vsync_lines <= wr_data[vsu_pkg::VSYNC_W-1:0];
            vsu_pkg::REG_FRAME_LINES:
               cfg_ff.frame_lines <= wr_data[vsu_pkg::LINES_W-1:0];
            vsu_pkg::REG_FIRST_VISIBLE:
               cfg_ff.first_visible_line <= wr_data[vsu_pkg::LINES_W-1:0];
            vsu_pkg::REG_VISIBLE_LINES:
               cfg_ff.visible_lines <= wr_data[vsu_pkg::VIS_LINES_W-1:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/vsu_timing.sv
// Line/pixel/frame counters and the per-tick sync and window decode.
// Depends on vsu_pkg.
`timescale 1ns / 1ps

module vsu_timing #(
   parameter int BUF_WIDTH  = vsu_pkg::DEF_BUF_WIDTH,
   parameter int BUF_HEIGHT = vsu_pkg::DEF_BUF_HEIGHT,
   localparam int COLI_W = $clog2(BUF_WIDTH),
   localparam int ROWI_W = $clog2(BUF_HEIGHT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  vsu_pkg::vsu_cfg_type  cfg,
   output vsu_pkg::vsu_sync_type sync,
   output logic [ROWI_W-1:0]     row,
   output logic [COLI_W-1:0]     col
);

   // column counter must hold BUF_WIDTH itself (end of line window)
   localparam int COL_W = $clog2(BUF_WIDTH + 1);
   localparam int LT_W  = vsu_pkg::LINE_TICKS_W;
   localparam int PT_W  = vsu_pkg::PIX_TICKS_W;
   localparam int LN_W  = vsu_pkg::LINES_W;

   logic [LT_W-1:0]  tick_ff, tick_in;
   logic [PT_W-1:0]  sub_ff, sub_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [LN_W-1:0]  line_ff, line_in;

   logic             in_window;
   logic [LN_W-1:0]  after_vs;
   logic [LN_W-1:0]  vis_off;
   logic             vis_range;
   logic [LN_W-2:0]  row_full;
   logic [PT_W-1:0]  pt;
   logic [PT_W:0]    sub_inc;
   logic [LT_W:0]    tick_inc;
   logic [LN_W:0]    line_inc;

   // decode from current state
   always_comb begin
      in_window = (tick_ff >= cfg.active_start) && (col_ff < COL_W'(BUF_WIDTH));
      after_vs  = line_ff - LN_W'(cfg.vsync_lines);
      vis_off   = after_vs - cfg.first_visible_line;
      vis_range = (line_ff >= LN_W'(cfg.vsync_lines))
               && (after_vs >= cfg.first_visible_line)
               && (vis_off < LN_W'(cfg.visible_lines));
      row_full  = vis_off[LN_W-1:1];   // each buffer row drawn on two lines

      sync.hsync_n = !(tick_ff < cfg.hsync_ticks);
      sync.vsync_n = !(line_ff < LN_W'(cfg.vsync_lines));
      sync.active  = in_window && vis_range
                  && (LN_W'(row_full) < LN_W'(BUF_HEIGHT));
      row = ROWI_W'(row_full);
      col = COLI_W'(col_ff);
   end

   // counter advance
   always_comb begin
      pt       = (cfg.pixel_ticks == '0) ? PT_W'(1) : cfg.pixel_ticks;
      sub_inc  = {1'b0, sub_ff} + (PT_W+1)'(1);
      tick_inc = {1'b0, tick_ff} + (LT_W+1)'(1);
      line_inc = {1'b0, line_ff} + (LN_W+1)'(1);
      sub_in   = sub_ff;
      col_in   = col_ff;
      tick_in  = tick_inc[LT_W-1:0];
      line_in  = line_ff;
      if (in_window) begin
         if (sub_inc >= {1'b0, pt}) begin
            sub_in = '0;
            col_in = col_ff + COL_W'(1);
         end else begin
            sub_in = sub_inc[PT_W-1:0];
         end
      end
      if (tick_inc >= {1'b0, cfg.line_ticks}) begin
         tick_in = '0;
         sub_in  = '0;
         col_in  = '0;
         line_in = (line_inc >= {1'b0, cfg.frame_lines}) ? '0 : line_inc[LN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         sub_ff  <= '0;
         col_ff  <= '0;
         line_ff <= '0;
      end else if (advance) begin
         tick_ff <= tick_in;
         sub_ff  <= sub_in;
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

endmodule

>>> rtl/vsu_fb.sv
// Frame buffer memory: one write and one registered read port, with the
// clearing sweep after reset. Depends on vsu_pkg.
`timescale 1ns / 1ps

module vsu_fb #(
   parameter int BUF_WIDTH  = vsu_pkg::DEF_BUF_WIDTH,
   parameter int BUF_HEIGHT = vsu_pkg::DEF_BUF_HEIGHT,
   localparam int COLI_W = $clog2(BUF_WIDTH),
   localparam int ROWI_W = $clog2(BUF_HEIGHT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  vsu_pkg::vsu_op_type          op,
   input  logic [ROWI_W-1:0]            row,
   input  logic [COLI_W-1:0]            col,
   input  logic [vsu_pkg::PIXEL_W-1:0]  wr_data,
   output logic [vsu_pkg::PIXEL_W-1:0]  rd_data,
   output logic                         clear_busy
);

   localparam int DEPTH  = BUF_WIDTH * BUF_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PIX_W  = vsu_pkg::PIXEL_W;

   logic [PIX_W-1:0]  mem [DEPTH];
   logic [PIX_W-1:0]  rd_ff;
   logic              clear_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [ADDR_W-1:0] addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_word;

   always_comb begin
      addr    = ADDR_W'(row) * ADDR_W'(BUF_WIDTH) + ADDR_W'(col);
      wr_en   = clear_ff || (enable && op.write);
      wr_addr = clear_ff ? clr_addr_ff : addr;
      wr_word = clear_ff ? '0 : wr_data;
   end

   // zeroing sweep, one word per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && op.read) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_data    = rd_ff;
   assign clear_busy = clear_ff;

endmodule

>>> rtl/vga_scanout_line_doubled_unit.sv
// Top level of the line-doubled VGA scan-out unit.
// Depends on vsu_pkg, vsu_csr, vsu_timing, vsu_fb and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   req channel: a word with tuser = tick advances the scan counters and
//   yields one rsp word (sync levels, active flag, pixel byte taken from the
//   state before the advance). A word with tuser = write stores one byte at
//   (row, column) of the frame buffer and yields no rsp word; out-of-range
//   positions are dropped.
//   csr channel: writes the timing registers, always ready; write only
//   while no tick is in flight.
// Path: address stage, then the buffer read into the output register.
// Throughput: one req word per cycle while rsp is not held and no sweep
//   runs, bounded by the single read and single write port of the frame
//   buffer. Writes and reads go through the same stage in order, so a
//   tick always sees every earlier write.
// Reset: counters and registers take their defaults, then the buffer's
//   BUF_WIDTH*BUF_HEIGHT words (76800 by default) are swept to zero
//   with req_tready low; csr writes are taken during the sweep.
// Stall: while the rsp word waits, the pipeline holds and req_tready
//   follows rsp_tready; no word is lost or repeated.

module vga_scanout_line_doubled_unit #(
   parameter int BUF_WIDTH  = vsu_pkg::DEF_BUF_WIDTH,
   parameter int BUF_HEIGHT = vsu_pkg::DEF_BUF_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [8:0] column, [16:9] row, [24:17] value, [31:25] zero
   input  logic [vsu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] kind
   input  logic [vsu_pkg::KIND_W-1:0]         req_tuser,
   // result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] hsync_n, [1] vsync_n, [2] active, [10:3] pixel_out, [15:11] zero
   output logic [vsu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vsu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vsu_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COLI_W = $clog2(BUF_WIDTH);
   localparam int ROWI_W = $clog2(BUF_HEIGHT);
   localparam int COL_LO = 0;
   localparam int ROW_LO = COL_LO + vsu_pkg::COLUMN_W;
   localparam int VAL_LO = ROW_LO + vsu_pkg::ROW_W;
   localparam int PIX_W  = vsu_pkg::PIXEL_W;

   vsu_pkg::vsu_cfg_type  cfg;
   vsu_pkg::vsu_sync_type dec_sync;
   logic [ROWI_W-1:0]     dec_row;
   logic [COLI_W-1:0]     dec_col;

   logic                       enable;
   logic                       clear_busy;
   logic                       accept;
   logic                       is_write;
   logic [vsu_pkg::COLUMN_W-1:0] req_column;
   logic [vsu_pkg::ROW_W-1:0]    req_row;
   logic [vsu_pkg::VALUE_W-1:0]  req_value;
   logic                       wr_ok;

   // address stage
   logic                  s1_tick_ff, s1_tick_in;
   vsu_pkg::vsu_op_type   s1_op_ff, s1_op_in;
   vsu_pkg::vsu_sync_type s1_sync_ff, s1_sync_in;
   logic [ROWI_W-1:0]     s1_row_ff, s1_row_in;
   logic [COLI_W-1:0]     s1_col_ff, s1_col_in;
   logic [PIX_W-1:0]      s1_value_ff, s1_value_in;

   // output register
   logic                  rsp_valid_ff;
   vsu_pkg::vsu_sync_type rsp_sync_ff;
   logic [PIX_W-1:0]      rd_data;
   logic [PIX_W-1:0]      rsp_pixel;

   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable && !clear_busy;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      req_column = req_tdata[ROW_LO-1:COL_LO];
      req_row    = req_tdata[VAL_LO-1:ROW_LO];
      req_value  = req_tdata[VAL_LO+vsu_pkg::VALUE_W-1:VAL_LO];
      is_write   = (req_tuser == vsu_pkg::KIND_WRITE);
      wr_ok      = (32'(req_column) < 32'(BUF_WIDTH)) && (32'(req_row) < 32'(BUF_HEIGHT));

      s1_tick_in    = accept && !is_write;
      s1_op_in.write = accept && is_write && wr_ok;
      s1_op_in.read  = accept && !is_write && dec_sync.active;
      s1_sync_in    = dec_sync;
      s1_value_in   = req_value;
      if (is_write) begin
         s1_row_in = ROWI_W'(req_row);
         s1_col_in = COLI_W'(req_column);
      end else begin
         s1_row_in = dec_row;
         s1_col_in = dec_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tick_ff   <= 1'b0;
         s1_op_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_tick_ff   <= s1_tick_in;
         s1_op_ff     <= s1_op_in;
         rsp_valid_ff <= s1_tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_sync_ff  <= s1_sync_in;
         s1_row_ff   <= s1_row_in;
         s1_col_ff   <= s1_col_in;
         s1_value_ff <= s1_value_in;
         rsp_sync_ff <= s1_sync_ff;
      end
   end

   vsu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   vsu_timing #(
      .BUF_WIDTH  (BUF_WIDTH),
      .BUF_HEIGHT (BUF_HEIGHT)
   ) u_timing (
      .clock   (clock),
      .reset   (reset),
      .advance (accept && !is_write),
      .cfg     (cfg),
      .sync    (dec_sync),
      .row     (dec_row),
      .col     (dec_col)
   );

   vsu_fb #(
      .BUF_WIDTH  (BUF_WIDTH),
      .BUF_HEIGHT (BUF_HEIGHT)
   ) u_fb (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .op         (s1_op_ff),
      .row        (s1_row_ff),
      .col        (s1_col_ff),
      .wr_data    (s1_value_ff),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   assign rsp_pixel  = rsp_sync_ff.active ? rd_data : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(vsu_pkg::RSP_DATA_W - PIX_W - 3){1'b0}}, rsp_pixel,
                        rsp_sync_ff.active, rsp_sync_ff.vsync_n, rsp_sync_ff.hsync_n};

   // ---- assertions ----
   `VSU_ASSERT_ALWAYS(a_sweep_after_reset, clock, reset |=> !req_tready, "req taken right after reset")
   `VSU_ASSERT(a_write_no_rsp, clock, reset, accept && is_write |=> !s1_tick_ff, "write word produced a result")
   `VSU_ASSERT(a_no_write_in_sweep, clock, reset, s1_op_ff.write |-> !clear_busy, "buffer write during clearing sweep")
   `VSU_ASSERT(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_tready |-> !req_tready, "req taken while output stalled")

endmodule

>>> sim/tb_vga_scanout_line_doubled_unit.sv
// Self-checking bench for the line-doubled VGA scan-out unit: drives tick and
// buffer-write words, predicts every scan word and compares it field by field.
// Depends on vsu_pkg and the vga_scanout_line_doubled_unit RTL.
`timescale 1ns / 1ps

module tb_vga_scanout_line_doubled_unit;

   localparam int BUF_W = vsu_pkg::DEF_BUF_WIDTH;
   localparam int BUF_H = vsu_pkg::DEF_BUF_HEIGHT;
   localparam int WATCHDOG_LIMIT = 300000;  // covers the buffer clear after reset
   localparam int LONG_HOLD = 200;

   typedef struct packed {
      logic [vsu_pkg::VALUE_W-1:0]  value;
      logic [vsu_pkg::ROW_W-1:0]    row;
      logic [vsu_pkg::COLUMN_W-1:0] column;
   } pixel_req_type;

   localparam int REQ_BODY_W = $bits(pixel_req_type);

   typedef struct packed {
      logic [vsu_pkg::KIND_W-1:0] kind;
      pixel_req_type              body;
   } req_item_type;

   typedef struct packed {
      logic [vsu_pkg::PIXEL_W-1:0] pixel_out;
      logic                        active;
      logic                        vsync_n;
      logic                        hsync_n;
   } scan_word_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_HALF} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [vsu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [vsu_pkg::KIND_W-1:0] req_tuser = vsu_pkg::KIND_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [vsu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [vsu_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [vsu_pkg::CSR_DATA_W-1:0] csr_data = '0;

   vga_scanout_line_doubled_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // shadow of the scan-out state
   vsu_pkg::vsu_cfg_type timing = vsu_pkg::CFG_RESET;
   logic [vsu_pkg::PIXEL_W-1:0] fbuf [BUF_W*BUF_H] = '{default: '0};
   int unsigned tick_pos = 0;
   int unsigned sub_cnt = 0;
   int unsigned col_pos = 0;
   int unsigned line_pos = 0;

   req_item_type req_backlog [$];
   scan_word_type scan_words_due [$];
   int errors = 0;
   int holds_asked = 0;

   // sync, active and pixel of the current tick, then advance the counters
   function automatic scan_word_type scan_tick();
      scan_word_type res;
      int unsigned span, row_idx, step;
      logic in_window, shown;
      res = '0;
      res.hsync_n = (tick_pos >= timing.hsync_ticks);
      res.vsync_n = (line_pos >= timing.vsync_lines);
      in_window = (tick_pos >= timing.active_start) && (col_pos < BUF_W);
      shown = 1'b0;
      row_idx = 0;
      if (line_pos >= timing.vsync_lines) begin
         span = line_pos - timing.vsync_lines;
         if (span >= timing.first_visible_line &&
             span - timing.first_visible_line < timing.visible_lines) begin
            row_idx = (span - timing.first_visible_line) / 2;
            shown = (row_idx < BUF_H);
         end
      end
      res.active = shown && in_window;
      if (res.active)
         res.pixel_out = fbuf[row_idx*BUF_W + col_pos];
      if (in_window) begin
         step = (timing.pixel_ticks == 0) ? 1 : timing.pixel_ticks;
         sub_cnt++;
         if (sub_cnt >= step) begin
            sub_cnt = 0;
            col_pos++;
         end
      end
      if (tick_pos + 1 >= timing.line_ticks) begin
         tick_pos = 0;
         sub_cnt = 0;
         col_pos = 0;
         line_pos = (line_pos + 1 >= timing.frame_lines) ? 0 : line_pos + 1;
      end else begin
         tick_pos++;
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function automatic vsu_pkg::vsu_cfg_type make_timing(input int lt, hs, st, pt, vs, fl,
                                                        fv, vl);
      vsu_pkg::vsu_cfg_type c;
      c.line_ticks = vsu_pkg::LINE_TICKS_W'(lt);
      c.hsync_ticks = vsu_pkg::LINE_TICKS_W'(hs);
      c.active_start = vsu_pkg::LINE_TICKS_W'(st);
      c.pixel_ticks = vsu_pkg::PIX_TICKS_W'(pt);
      c.vsync_lines = vsu_pkg::VSYNC_W'(vs);
      c.frame_lines = vsu_pkg::LINES_W'(fl);
      c.first_visible_line = vsu_pkg::LINES_W'(fv);
      c.visible_lines = vsu_pkg::VIS_LINES_W'(vl);
      return c;
   endfunction

   // request driver: bursts of random length with random gaps
   int burst_left, gap_left;
   always @(posedge clock) begin : drive_req
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 1;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0 || req_backlog.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left != 0)
               gap_left <= gap_left - 1;
         end else begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.kind;
            req_tdata <= vsu_pkg::REQ_DATA_W'(nxt.body);
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // result receiver: random stall modes plus an occasional long hold
   stall_mode_type ready_mode = RDY_ALWAYS;
   int mode_left = 0;
   int hold_left = 0;
   int holds_taken = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_taken != holds_asked) begin
         holds_taken <= holds_taken + 1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left <= $urandom_range(16, 96);
            ready_mode <= stall_mode_type'($urandom_range(0, 2));
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            default:    rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // monitor: register shadow, result check, prediction
   always @(posedge clock) begin : monitor
      scan_word_type got, want;
      pixel_req_type wr;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (vsu_pkg::vsu_reg_type'(csr_index))
               vsu_pkg::REG_LINE_TICKS:
                  timing.line_ticks = csr_data;
               vsu_pkg::REG_HSYNC_TICKS:
                  timing.hsync_ticks = csr_data;
               vsu_pkg::REG_ACTIVE_START:
                  timing.active_start = csr_data;
               vsu_pkg::REG_PIXEL_TICKS:
                  timing.pixel_ticks = csr_data[vsu_pkg::PIX_TICKS_W-1:0];
               vsu_pkg::REG_VSYNC_LINES:
                  timing.vsync_lines = csr_data[vsu_pkg::VSYNC_W-1:0];
               vsu_pkg::REG_FRAME_LINES:
                  timing.frame_lines = csr_data[vsu_pkg::LINES_W-1:0];
               vsu_pkg::REG_FIRST_VISIBLE:
                  timing.first_visible_line = csr_data[vsu_pkg::LINES_W-1:0];
               vsu_pkg::REG_VISIBLE_LINES:
                  timing.visible_lines = csr_data[vsu_pkg::VIS_LINES_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(scan_word_type)-1:0];
            if (scan_words_due.size() == 0) begin
               $error("result word %h with no tick waiting", rsp_tdata);
               errors++;
            end else begin
               want = scan_words_due.pop_front();
               check_field("hsync_n", want.hsync_n, got.hsync_n);
               check_field("vsync_n", want.vsync_n, got.vsync_n);
               check_field("active", want.active, got.active);
               check_field("pixel_out", want.pixel_out, got.pixel_out);
            end
         end
         if (req_tvalid && req_tready) begin
            wr = req_tdata[REQ_BODY_W-1:0];
            if (req_tuser == vsu_pkg::KIND_WRITE) begin
               if (wr.column < BUF_W && wr.row < BUF_H)
                  fbuf[wr.row*BUF_W + wr.column] = wr.value;
            end else begin
               scan_words_due.push_back(scan_tick());
            end
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_item(input logic [vsu_pkg::KIND_W-1:0] kind, input int column, row,
                             value);
      req_item_type it;
      it.kind = kind;
      it.body.column = vsu_pkg::COLUMN_W'(column);
      it.body.row = vsu_pkg::ROW_W'(row);
      it.body.value = vsu_pkg::VALUE_W'(value);
      req_backlog.push_back(it);
   endtask

   // most writes land where the current timing reads them back
   task automatic queue_random(input int count, write_pct, row_hi, col_hi);
      req_item_type it;
      repeat (count) begin
         it.body = REQ_BODY_W'($urandom);
         if ($urandom_range(1, 100) <= write_pct) begin
            it.kind = vsu_pkg::KIND_WRITE;
            if ($urandom_range(0, 4) != 0) begin
               it.body.row = vsu_pkg::ROW_W'($urandom_range(0, row_hi));
               it.body.column = vsu_pkg::COLUMN_W'($urandom_range(0, col_hi));
            end
         end else begin
            it.kind = vsu_pkg::KIND_TICK;
         end
         req_backlog.push_back(it);
      end
   endtask

   // sender stays quiet until every scan word is back, then the pipe settles
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || scan_words_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all eight registers back to back; junk above the narrow fields
   task automatic program_timing(input vsu_pkg::vsu_cfg_type cfg);
      logic [vsu_pkg::CSR_DATA_W-1:0] vals [8];
      vals[0] = cfg.line_ticks;
      vals[1] = cfg.hsync_ticks;
      vals[2] = cfg.active_start;
      vals[3] = {9'($urandom), cfg.pixel_ticks};
      vals[4] = {9'($urandom), cfg.vsync_lines};
      vals[5] = {3'($urandom), cfg.frame_lines};
      vals[6] = {3'($urandom), cfg.first_visible_line};
      vals[7] = {4'($urandom), cfg.visible_lines};
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= vsu_pkg::vsu_reg_type'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input vsu_pkg::vsu_cfg_type cfg, input int count, write_pct,
                            row_hi, col_hi);
      wait_drained();
      program_timing(cfg);
      queue_random(count, write_pct, row_hi, col_hi);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // buffer corners, dropped out-of-range writes, ticks at reset timing
      queue_item(vsu_pkg::KIND_WRITE, 0, 0, 8'hFF);
      queue_item(vsu_pkg::KIND_WRITE, BUF_W-1, 0, 8'hA5);
      queue_item(vsu_pkg::KIND_WRITE, 0, BUF_H-1, 8'h5A);
      queue_item(vsu_pkg::KIND_WRITE, BUF_W-1, BUF_H-1, 8'hFF);
      queue_item(vsu_pkg::KIND_WRITE, BUF_W, 7, 8'h33);
      queue_item(vsu_pkg::KIND_WRITE, 9, BUF_H, 8'h33);
      queue_item(vsu_pkg::KIND_WRITE, 511, 255, 8'hFF);
      queue_item(vsu_pkg::KIND_TICK, 0, 0, 0);
      queue_item(vsu_pkg::KIND_TICK, 511, 255, 255);
      queue_item(vsu_pkg::KIND_TICK, 0, 0, 0);
      queue_item(vsu_pkg::KIND_TICK, 0, 0, 0);

      // one tick per line: vsync, a hidden line, then rows 0 and 1 twice each
      wait_drained();
      program_timing(make_timing(1, 0, 0, 1, 1, 6, 1, 4));
      queue_item(vsu_pkg::KIND_WRITE, 0, 1, 8'h3C);
      repeat (8) queue_item(vsu_pkg::KIND_TICK, 0, 0, 0);

      // small frame, zero pixel length; the receiver holds off while words keep coming
      wait_drained();
      program_timing(make_timing(12, 2, 3, 0, 1, 10, 1, 6));
      holds_asked <= holds_asked + 1;
      queue_random(60, 30, 3, 5);

      // line long enough to reach the last column
      run_phase(make_timing(330, 40, 0, 1, 0, 8, 0, 480), 370, 6, 4, BUF_W-1);
      // every register at its largest value
      run_phase(make_timing(8191, 8191, 8191, 15, 15, 1023, 1023, 511), 20, 30, 0, 0);
      run_phase(make_timing(48, 6, 4, 15, 2, 12, 1, 8), 50, 20, 4, 3);
      // zero line and frame length: every tick wraps both counters
      run_phase(make_timing(0, 0, 0, 1, 0, 0, 0, 2), 30, 20, 1, 0);
      // active start and hsync end both past the end of the line
      run_phase(make_timing(20, 25, 25, 3, 3, 9, 2, 3), 40, 20, 2, 3);

      wait_drained();
      repeat (16) @(posedge clock);
      if (errors == 0 && scan_words_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
